/* design/extent_node_address_translator_defines.svh */
// Assertion macros shared by the extent node address translator RTL.
`ifndef EXTENT_NODE_ADDRESS_TRANSLATOR_DEFINES_SVH
`define EXTENT_NODE_ADDRESS_TRANSLATOR_DEFINES_SVH

// Same-cycle implication on clk, masked during rst.
`define ENAT_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, masked during rst.
`define ENAT_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/enat_pkg.sv */
// Types and constants shared by the extent node address translator.
package enat_pkg;

  localparam int EXTENT_SLOTS = 8;
  localparam int IDX_W = (EXTENT_SLOTS > 1) ? $clog2(EXTENT_SLOTS) : 1;

  localparam int SLOT_W = 3;
  localparam int WORD_W = 32;
  localparam int OFF_W  = 64;
  localparam int BS_W   = 32;
  localparam int NS_W   = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VSO = 2'd0,
    CFG_BS  = 2'd1,
    CFG_NS  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XLATE = 1'b1
  } op_t;

  // Classification of an accepted item.
  typedef enum logic [1:0] {
    K_LOAD,
    K_NODE0,
    K_XLATE,
    K_SKIP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] start;
    logic [WORD_W-1:0] count;
    logic [WORD_W-1:0] node;
  } entry_t;

  typedef struct packed {
    logic [OFF_W-1:0] volume_start_offset;
    logic [BS_W-1:0]  block_size;
    logic [NS_W-1:0]  node_size;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_TEST,
    ST_DIV,
    ST_OMUL,
    ST_OADD,
    ST_RESP
  } state_t;

endpackage

/* design/enat_ifs.sv */
// Valid/ready stream interfaces for the request and response channels.
interface enat_req_if import enat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [SLOT_W-1:0] extent_slot;
  logic [WORD_W-1:0] start_block;
  logic [WORD_W-1:0] block_count;
  logic [WORD_W-1:0] node_number;

  modport source (output valid, opcode, extent_slot, start_block, block_count,
                  node_number, input ready);
  modport sink (input valid, opcode, extent_slot, start_block, block_count,
                node_number, output ready);
endinterface

interface enat_rsp_if import enat_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] byte_offset;
  logic             found;

  modport source (output valid, byte_offset, found, input ready);
  modport sink (input valid, byte_offset, found, output ready);
endinterface

/* design/extent_node_address_translator.sv */
// Extent node address translator: top level with configuration registers.
//
// Requests arrive on req (valid/ready). opcode 0 loads extent_slot with
// start_block and block_count; it gives no response. opcode 1 translates
// node_number and gives one response on rsp: byte_offset and found.
// Items are carried out strictly in order, so a translate sees every load
// accepted before it. Configuration is written by the user through cfg_we,
// cfg_index and cfg_data while the block is idle, which the block does not
// enforce: 0 volume start, 1 block size, 2 node size; other indexes ignored.
// A two-entry queue separates the front end from the engine, so req keeps
// taking transfers while the engine works or rsp is stalled, until it fills.
// Node 0 goes straight to the offset multiply and add; any other node under a
// zero node size gives a miss response; else the walk passes extents in order
// until a hit or all eight are passed. A load is taken while the engine idles.
// Each extent passed costs a product, a compare and a 32-step restoring
// division of its node capacity, one quotient bit per cycle; one item at a time.
// A response waits in its output register while rsp.ready is low; the
// engine then holds and the queue fills. Synchronous reset clears the
// extent table, the queue and the response register, and loads the
// configuration defaults (0, 4096, 4096).
module extent_node_address_translator import enat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  enat_req_if.sink              req,
  enat_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  entry_t q_wdata;
  entry_t q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volume_start_offset <= '0;
      cfg.block_size          <= BS_W'(4096);
      cfg.node_size           <= NS_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_VSO: cfg.volume_start_offset <= cfg_data;
        CFG_BS:  cfg.block_size          <= cfg_data[BS_W-1:0];
        CFG_NS:  cfg.node_size           <= cfg_data[NS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  enat_front u_front (
    .req     (req),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_wdata)
  );

  enat_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  enat_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

/* design/enat_front.sv */
// Front end: accepts request transfers and classifies them for the queue.
module enat_front import enat_pkg::*; (
  enat_req_if.sink req,
  input  logic     q_full,
  output logic     q_push,
  output entry_t   q_entry
);

  kind_t kind;

  always_comb begin
    unique case (op_t'(req.opcode))
      OP_LOAD: begin
        // drop loads aimed past the table
        kind = (int'(req.extent_slot) < EXTENT_SLOTS) ? K_LOAD : K_SKIP;
      end
      OP_XLATE: begin
        kind = (req.node_number == '0) ? K_NODE0 : K_XLATE;
      end
      default: kind = K_SKIP;
    endcase
  end

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full && (kind != K_SKIP);

  always_comb begin
    q_entry.kind  = kind;
    q_entry.slot  = req.extent_slot;
    q_entry.start = req.start_block;
    q_entry.count = req.block_count;
    q_entry.node  = req.node_number;
  end

endmodule

/* design/enat_queue.sv */
// Short queue between the front end and the translation engine.
module enat_queue import enat_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wdata,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t rdata
);

  entry_t              entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;

  assign full  = (fill == QCNT_W'(QDEPTH));
  assign empty = (fill == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* design/enat_back.sv */
// Translation engine: extent table, extent walk, divider and result register.
`include "extent_node_address_translator_defines.svh"

module enat_back import enat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_empty,
  input  entry_t     q_data,
  output logic       q_pop,
  enat_rsp_if.source rsp
);

  localparam int NEED_W = WORD_W + 1 + NS_W;   // (rem + 1) * node_size
  localparam int DVD_W  = WORD_W + NS_W;       // dividend bound on a miss
  localparam int DCNT_W = $clog2(WORD_W);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(EXTENT_SLOTS - 1);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(WORD_W - 1);

  logic [WORD_W-1:0] start_tab [EXTENT_SLOTS];
  logic [WORD_W-1:0] count_tab [EXTENT_SLOTS];

  state_t              state;
  state_t              state_next;
  logic [IDX_W-1:0]    idx;
  logic [WORD_W-1:0]   rem;
  logic [OFF_W-1:0]    prod;
  logic [NEED_W-1:0]   need;
  logic [DVD_W-1:0]    dvd;
  logic [DVD_W-1:0]    dsr;
  logic [WORD_W-1:0]   quo;
  logic [DCNT_W-1:0]   dcnt;
  logic [OFF_W-1:0]    pa;
  logic [DVD_W-1:0]    pb;
  logic [OFF_W-1:0]    res_off;
  logic                res_found;
  logic                out_valid;
  logic [OFF_W-1:0]    out_off;
  logic                out_found;

  logic                hit;
  logic                out_free;
  logic                out_load;
  logic                dstep;
  logic [WORD_W-1:0]   quo_next;

  // node lies in this extent when (rem + 1) * node_size <= count * block_size
  assign hit      = ({{(OFF_W - NEED_W){1'b0}}, need} <= prod);
  assign out_free = !out_valid || rsp.ready;
  assign dstep    = (dvd >= dsr);
  assign quo_next = {quo[WORD_W-2:0], dstep};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_data.kind)
            K_NODE0: state_next = ST_OMUL;
            K_XLATE: state_next = (cfg.node_size == '0) ? ST_RESP : ST_PROD;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_PROD: state_next = ST_TEST;
      ST_TEST: state_next = hit ? ST_OMUL : ST_DIV;
      ST_DIV: begin
        if (dcnt == DCNT_LAST) begin
          state_next = (idx == IDX_LAST) ? ST_RESP : ST_PROD;
        end
      end
      ST_OMUL: state_next = ST_OADD;
      ST_OADD: state_next = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state == ST_IDLE) && !q_empty;
    out_load = (state == ST_RESP) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < EXTENT_SLOTS; i++) begin
        start_tab[i] <= '0;
        count_tab[i] <= '0;
      end
    end else if (q_pop && q_data.kind == K_LOAD) begin
      start_tab[IDX_W'(q_data.slot)] <= q_data.start;
      count_tab[IDX_W'(q_data.slot)] <= q_data.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      dcnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          idx       <= '0;
          rem       <= q_data.node;
          res_off   <= '0;
          res_found <= 1'b0;
        end
        ST_PROD: begin
          prod <= OFF_W'(count_tab[idx]) * OFF_W'(cfg.block_size);
          need <= NEED_W'({1'b0, rem} + (WORD_W + 1)'(1)) * NEED_W'(cfg.node_size);
        end
        ST_TEST: begin
          dvd  <= prod[DVD_W-1:0];
          dsr  <= {1'b0, cfg.node_size, {(WORD_W - 1){1'b0}}};
          quo  <= '0;
          dcnt <= '0;
        end
        ST_DIV: begin
          // one restoring step per cycle
          if (dstep) begin
            dvd <= dvd - dsr;
          end
          dsr  <= dsr >> 1;
          quo  <= quo_next;
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_LAST) begin
            rem <= rem - quo_next;
            if (idx != IDX_LAST) begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_OMUL: begin
          pa <= OFF_W'(start_tab[idx]) * OFF_W'(cfg.block_size);
          pb <= DVD_W'(rem) * DVD_W'(cfg.node_size);
        end
        ST_OADD: begin
          res_off   <= cfg.volume_start_offset + pa + OFF_W'(pb);
          res_found <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_off   <= res_off;
      out_found <= res_found;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.byte_offset = out_off;
  assign rsp.found       = out_found;

  `ENAT_CHECK(a_div_nonzero, state == ST_DIV, cfg.node_size != '0, "division by zero node size")
  `ENAT_CHECK(a_div_bound, state == ST_DIV, {1'b0, dvd} < {dsr, 1'b0}, "quotient overflow")
  `ENAT_CHECK_NEXT(a_load_idle, q_pop && q_data.kind == K_LOAD, state == ST_IDLE, "load left idle")

endmodule

/* bench/extent_node_address_translator_test.sv */
// Self-checking testbench for the extent node address translator.
module extent_node_address_translator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import enat_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int DRAIN_CYCLES = 320;
  localparam int RANDOM_ITEMS = 1500;
  localparam logic [63:0] NODE_SPAN = 64'h1_0000_0000;

  typedef struct packed {
    logic [OFF_W-1:0] byte_offset;
    logic             found;
  } node_offset_t;

  class node_offset_tracker;
    logic [OFF_W-1:0]  volume_start;
    logic [BS_W-1:0]   block_bytes;
    logic [NS_W-1:0]   node_bytes;
    logic [WORD_W-1:0] start_tbl [EXTENT_SLOTS];
    logic [WORD_W-1:0] count_tbl [EXTENT_SLOTS];
    node_offset_t      pending_offsets [$];
    int unsigned       mismatches;

    function new();
      volume_start = '0;
      block_bytes = 32'd4096;
      node_bytes = 16'd4096;
      mismatches = 0;
      foreach (start_tbl[i]) begin
        start_tbl[i] = '0;
        count_tbl[i] = '0;
      end
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_VSO: volume_start = data;
        CFG_BS:  block_bytes = data[BS_W-1:0];
        CFG_NS:  node_bytes = data[NS_W-1:0];
        default: ;
      endcase
    endfunction

    // Nodes held by one extent; none when the node size is zero.
    function logic [63:0] capacity(int slot);
      if (node_bytes == '0) return '0;
      return (64'(count_tbl[slot]) * 64'(block_bytes)) / 64'(node_bytes);
    endfunction

    // First node number of an extent; saturates once past every 32-bit node.
    function logic [63:0] extent_base(int upto);
      logic [63:0] base;
      logic [63:0] cap;
      base = '0;
      for (int i = 0; i < upto; i++) begin
        cap = capacity(i);
        if (cap > NODE_SPAN - base) base = NODE_SPAN;
        else base += cap;
      end
      return base;
    endfunction

    function node_offset_t translate_node(logic [WORD_W-1:0] node);
      node_offset_t res;
      logic [63:0] base;
      logic [63:0] cap;
      res = '0;
      base = '0;
      if (node == '0) begin
        res.byte_offset = volume_start + 64'(start_tbl[0]) * 64'(block_bytes);
        res.found = 1'b1;
        return res;
      end
      for (int i = 0; i < EXTENT_SLOTS; i++) begin
        cap = capacity(i);
        if (64'(node) >= base && 64'(node) - base < cap) begin
          res.byte_offset = volume_start + 64'(start_tbl[i]) * 64'(block_bytes)
                          + (64'(node) - base) * 64'(node_bytes);
          res.found = 1'b1;
          return res;
        end
        if (cap > NODE_SPAN - base) base = NODE_SPAN;
        else base += cap;
      end
      return res;
    endfunction

    function void note_request(op_t op, logic [SLOT_W-1:0] slot,
                               logic [WORD_W-1:0] start, logic [WORD_W-1:0] count,
                               logic [WORD_W-1:0] node);
      if (op == OP_LOAD) begin
        if (slot < EXTENT_SLOTS) begin
          start_tbl[slot] = start;
          count_tbl[slot] = count;
        end
      end else begin
        pending_offsets.push_back(translate_node(node));
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      $display("%0t: %s", $time, msg);
    endfunction

    function void check_response(logic [OFF_W-1:0] byte_offset, logic found);
      node_offset_t want;
      if (pending_offsets.size() == 0) begin
        flag($sformatf("response with none expected: byte_offset %h found %b",
                       byte_offset, found));
        return;
      end
      want = pending_offsets.pop_front();
      if (byte_offset !== want.byte_offset)
        flag($sformatf("byte_offset mismatch: expected %h, actual %h",
                       want.byte_offset, byte_offset));
      if (found !== want.found)
        flag($sformatf("found mismatch: expected %b, actual %b", want.found, found));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           cycle_count = 0;
  bit                    src_calm = 1'b0;
  bit                    sink_calm = 1'b0;
  node_offset_tracker    board;

  enat_req_if req_ch ();
  enat_rsp_if rsp_ch ();

  extent_node_address_translator dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Track every transfer on both channels.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      board.note_request(op_t'(req_ch.opcode), req_ch.extent_slot, req_ch.start_block,
                         req_ch.block_count, req_ch.node_number);
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      board.check_response(rsp_ch.byte_offset, rsp_ch.found);
  end

  task automatic send_item(op_t op, logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] start,
                           logic [WORD_W-1:0] count, logic [WORD_W-1:0] node);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.extent_slot <= slot;
    req_ch.start_block <= start;
    req_ch.block_count <= count;
    req_ch.node_number <= node;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Fill the fields a request ignores with noise.
  task automatic send_load(logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] start,
                           logic [WORD_W-1:0] count);
    send_item(OP_LOAD, slot, start, count, $urandom());
  endtask

  task automatic send_xlate(logic [WORD_W-1:0] node);
    send_item(OP_XLATE, SLOT_W'($urandom_range(0, 7)), $urandom(), $urandom(), node);
  endtask

  // Hold requests off until every lookup has answered and loads have settled.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (board.pending_offsets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers; upper data bits carry noise the block must drop.
  task automatic configure(logic [OFF_W-1:0] vso, logic [BS_W-1:0] bs, logic [NS_W-1:0] ns);
    logic [CFG_DATA_W-1:0] bs_word;
    logic [CFG_DATA_W-1:0] ns_word;
    bs_word = {$urandom(), bs};
    ns_word = {$urandom(), 16'($urandom()), ns};
    cfg_we <= 1'b1;
    cfg_index <= CFG_VSO;
    cfg_data <= vso;
    board.write_reg(CFG_VSO, vso);
    @(posedge clk);
    cfg_index <= CFG_BS;
    cfg_data <= bs_word;
    board.write_reg(CFG_BS, bs_word);
    @(posedge clk);
    cfg_index <= CFG_NS;
    cfg_data <= ns_word;
    board.write_reg(CFG_NS, ns_word);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_count();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom();
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  // Aim at extent boundaries and the populated range, with some noise.
  function automatic logic [WORD_W-1:0] pick_node();
    logic [63:0] total;
    logic [63:0] edge_at;
    logic [31:0] hi;
    total = board.extent_base(EXTENT_SLOTS);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom();
      2, 3, 4: begin
        edge_at = board.extent_base($urandom_range(0, EXTENT_SLOTS))
                + 64'($urandom_range(0, 2)) - 64'd1;
        return edge_at[WORD_W-1:0];
      end
      default: begin
        if (total < 64'd2) return $urandom_range(0, 3);
        hi = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0] - 32'd1;
        return $urandom_range(1, hi);
      end
    endcase
  endfunction

  initial begin : sink_side
    int unsigned stall;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  initial begin : watchdog
    wait (cycle_count >= LIMIT_CYCLES);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_len;
    logic [OFF_W-1:0] vso;
    logic [BS_W-1:0] bs;
    logic [NS_W-1:0] ns;
    board = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_VSO;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_LOAD;
    req_ch.extent_slot <= '0;
    req_ch.start_block <= '0;
    req_ch.block_count <= '0;
    req_ch.node_number <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults with an empty table, then full-width extents.
    send_xlate('0);
    send_xlate(32'd1);
    send_load(3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_load(3'd7, 32'd1, 32'd2);
    send_xlate('0);
    send_xlate(32'hFFFF_FFFE);
    send_xlate(32'hFFFF_FFFF);
    drain();
    // Largest volume start and block size: offsets wrap.
    configure('1, '1, 16'd1);
    send_xlate('0);
    send_xlate(32'd5);
    send_xlate(32'hFFFF_FFFF);
    drain();
    // Zero node size: only node zero resolves.
    configure(64'd0, 32'd4096, 16'd0);
    send_xlate('0);
    send_xlate(32'd1);
    drain();
    // Zero block size: every extent is empty.
    configure(64'd5, 32'd0, 16'd512);
    send_xlate('0);
    send_xlate(32'd3);
    drain();
    // Empty first extent still hosts node zero.
    configure(64'h1000, 32'd1, 16'hFFFF);
    send_load(3'd0, 32'd0, 32'd0);
    send_load(3'd1, 32'd100, 32'h0002_0000);
    send_xlate('0);
    send_xlate(32'd1);
    send_xlate(32'd2);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      case ($urandom_range(0, 3))
        0: vso = '0;
        1: vso = '1;
        default: vso = {$urandom(), $urandom()};
      endcase
      case ($urandom_range(0, 9))
        0: bs = 32'd1;
        1: bs = 32'hFFFF_FFFF;
        2: bs = 32'd0;
        3, 4: bs = 32'd512;
        5: bs = $urandom_range(1, 65536);
        default: bs = 32'd4096;
      endcase
      case ($urandom_range(0, 9))
        0: ns = 16'd1;
        1: ns = 16'hFFFF;
        2: ns = 16'd0;
        3: ns = 16'd512;
        4: ns = 16'd8192;
        5: ns = 16'($urandom_range(1, 65535));
        default: ns = 16'd4096;
      endcase
      configure(vso, bs, ns);
      if ($urandom_range(0, 3) != 0) begin
        for (int s = 0; s < EXTENT_SLOTS; s++) begin
          send_load(SLOT_W'(s), $urandom(), pick_count());
          sent++;
        end
      end
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        if ($urandom_range(0, 4) == 0)
          send_load(SLOT_W'($urandom_range(0, 7)), $urandom(), pick_count());
        else
          send_xlate(pick_node());
        sent++;
      end
    end
    drain();

    if (board.mismatches == 0 && board.pending_offsets.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
